### sv/wefd_pkg.sv
// Package for the 1D wave equation finite-difference stepper.
// Holds field widths, register indexes, defaults and saturation limits.
// No dependencies; the top level of the stepper and its bench use it.
package wefd_pkg;

   // Defaults for the top level parameters
   localparam int MAX_COLUMNS_DEF = 64;
   localparam int FRAC_BITS_DEF   = 16;

   // Field widths
   localparam int VAL_W      = 32;
   localparam int COL_W      = 6;
   localparam int A2_W       = 18;
   localparam int RSP_PAD_W  = 2;
   localparam int RSP_DATA_W = COL_W + VAL_W + RSP_PAD_W;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_ALPHA_SQUARED = 2'd0,
      REG_SOURCE_COLUMN = 2'd1,
      REG_LAST_COLUMN   = 2'd2
   } csr_reg_type;

   localparam logic [A2_W-1:0]  ALPHA_SQUARED_RST = 18'd65536;
   localparam logic [COL_W-1:0] SOURCE_COLUMN_RST = 6'd32;
   localparam logic [COL_W-1:0] LAST_COLUMN_RST   = 6'd63;

   // Time step phase: zero steps first, then the stencil runs
   localparam logic [1:0] PHASE_RUN = 2'd2;

   localparam logic [VAL_W-1:0] VALUE_MAX = 32'h7fff_ffff;
   localparam logic [VAL_W-1:0] VALUE_MIN = 32'h8000_0000;

endpackage

### sv/wefd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Used for the two stored grid rows of the stepper. No dependencies.
module wefd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/wave_equation_fd_stepper.sv
// Top level of the 1D wave equation stepper: sequencer, shared multiplier,
// accumulator and register port. Depends on wefd_pkg and wefd_ram.
//
//   port group | role          | tdata / tuser contents
//   req_       | step request  | tdata: source_sample; tuser: restart
//   rsp_       | grid values   | tdata: column, value; tuser: overflow; tlast: last
//   csr_       | registers     | alpha_squared, source_column, last_column
//
// In a stencil step one shared multiplier is used twice per column and each row
// RAM has one read port. The first two steps after reset or restart sweep all
// MAX_COLUMNS entries of both rows to zero, one entry a cycle while the rsp_ side
// takes the zeros it is sent. req_tready is high only between steps.
// A stalled rsp_ side holds the sequencer on the pending column.
// Reset is synchronous and clears control state and registers.
module wave_equation_fd_stepper #(
   parameter int MAX_COLUMNS = wefd_pkg::MAX_COLUMNS_DEF,
   parameter int FRAC_BITS   = wefd_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wefd_pkg::VAL_W-1:0]         req_tdata,   // [31:0] source_sample
   input  logic [0:0]                         req_tuser,   // [0] restart
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wefd_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [5:0] column, [37:6] value, [39:38] zero
   output logic [0:0]                         rsp_tuser,   // [0] overflow
   output logic                               rsp_tlast,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wefd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wefd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wefd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import wefd_pkg::*;

   localparam int IDX_W = $clog2(MAX_COLUMNS);
   localparam int CW    = (IDX_W > COL_W) ? IDX_W : COL_W;
   localparam int AW    = ((FRAC_BITS + 1 > A2_W) ? FRAC_BITS + 1 : A2_W) + 1;
   localparam int PW    = AW + VAL_W + 1;
   localparam int ACC_W = PW + 3;
   localparam int HI_W  = ACC_W - VAL_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_COLUMNS - 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CLEAR = 8'b0000_0010,
      ST_PRIME = 8'b0000_0100,
      ST_READ  = 8'b0000_1000,
      ST_MUL1  = 8'b0001_0000,
      ST_MUL2  = 8'b0010_0000,
      ST_ACC   = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type                state_ff, state_in;
   logic [1:0]               phase_ff, phase_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic [IDX_W-1:0]         bound_ff, bound_in;
   logic [VAL_W-1:0]         src_ff, src_in;
   logic [VAL_W-1:0]         left_ff, left_in;
   logic [VAL_W-1:0]         mid_ff, mid_in;
   logic [VAL_W-1:0]         right_ff, right_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]         rsp_col_ff, rsp_col_in;
   logic [VAL_W-1:0]         rsp_value_ff, rsp_value_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [A2_W-1:0]          a2_ff, a2_in;
   logic [COL_W-1:0]         src_col_ff, src_col_in;
   logic [COL_W-1:0]         last_col_ff, last_col_in;

   logic                     wr_en;
   logic [VAL_W-1:0]         prev_wdata, older_wdata, prev_rd, older_rd;
   logic [IDX_W-1:0]         prev_raddr, next_idx;

   logic                     out_free, is_edge, right_zero, src_hit, csr_write;
   logic [CW-1:0]            j_wide, lc_wide;
   logic [IDX_W-1:0]         bound_calc;
   logic [1:0]               phase_eff;
   logic [VAL_W-1:0]         left_n, right_n;
   logic signed [VAL_W:0]    nbr_sum;
   logic signed [AW-1:0]     mul_a, one_minus_a2;
   logic signed [VAL_W:0]    mul_b;
   logic signed [ACC_W-1:0]  prod_ext, older_term, src_term, half_term, q;
   logic [HI_W-1:0]          q_hi;
   logic                     sat;
   logic [VAL_W-1:0]         fresh;
   logic                     fresh_ovf;

   wefd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_prev_row (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (j_ff),
      .wr_data (prev_wdata),
      .rd_addr (prev_raddr),
      .rd_data (prev_rd)
   );

   wefd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_older_row (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (j_ff),
      .wr_data (older_wdata),
      .rd_addr (j_ff),
      .rd_data (older_rd)
   );

   // Column bookkeeping
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign j_wide     = CW'(j_ff);
   assign lc_wide    = CW'(last_col_ff);
   assign bound_calc = (lc_wide > CW'(MAX_COLUMNS - 1)) ? LAST_IDX : IDX_W'(lc_wide);
   assign is_edge    = (j_ff == '0) || (j_ff == bound_ff);
   assign right_zero = ((IDX_W + 1)'(j_ff) + (IDX_W + 1)'(1)) >= (IDX_W + 1)'(bound_ff);
   assign src_hit    = !is_edge && (j_wide == CW'(src_col_ff));
   assign next_idx   = (j_ff == LAST_IDX) ? '0 : j_ff + IDX_W'(1);
   assign prev_raddr = (state_ff == ST_PRIME) ? '0 : next_idx;
   assign phase_eff  = req_tuser[0] ? 2'd0 : phase_ff;

   // Boundary columns act as zero neighbours
   assign left_n  = (j_ff == IDX_W'(1)) ? '0 : left_ff;
   assign right_n = right_zero ? '0 : prev_rd;
   assign nbr_sum = $signed({left_n[VAL_W-1], left_n}) + $signed({right_n[VAL_W-1], right_n});

   // Shared multiplier: a2 * (left + right), then (1 - a2) * mid
   assign one_minus_a2 = $signed(AW'(1) << FRAC_BITS) - $signed(AW'(a2_ff));
   assign mul_a   = (state_ff == ST_MUL1) ? $signed(AW'(a2_ff)) : one_minus_a2;
   assign mul_b   = (state_ff == ST_MUL1) ? nbr_sum : $signed({mid_ff[VAL_W-1], mid_ff});
   assign prod_in = mul_a * mul_b;

   assign prod_ext   = ACC_W'(prod_ff);
   assign older_term = ACC_W'($signed(older_rd)) <<< FRAC_BITS;
   assign src_term   = src_hit ? (ACC_W'($signed(src_ff)) <<< FRAC_BITS) : '0;
   assign half_term  = ACC_W'(1) <<< (FRAC_BITS - 1);

   // Round half up is folded into the accumulator; floor and saturate here
   assign q         = acc_ff >>> FRAC_BITS;
   assign q_hi      = q[ACC_W-1:VAL_W-1];
   assign sat       = !((&q_hi) || !(|q_hi));
   assign fresh     = is_edge ? '0 :
                      (sat ? (q[ACC_W-1] ? VALUE_MIN : VALUE_MAX) : q[VAL_W-1:0]);
   assign fresh_ovf = !is_edge && sat;

   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      j_in         = j_ff;
      bound_in     = bound_ff;
      src_in       = src_ff;
      left_in      = left_ff;
      mid_in       = mid_ff;
      right_in     = right_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      prev_wdata   = '0;
      older_wdata  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               src_in   = req_tdata;
               bound_in = bound_calc;
               j_in     = '0;
               if (phase_eff < PHASE_RUN) begin
                  phase_in = phase_eff + 2'd1;
                  state_in = ST_CLEAR;
               end else begin
                  phase_in = PHASE_RUN;
                  state_in = ST_PRIME;
               end
            end
         end
         ST_CLEAR: begin
            // Sweep every entry to zero; emit zeros up to the boundary
            if (j_ff > bound_ff || out_free) begin
               wr_en = 1'b1;
               if (j_ff <= bound_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_col_in   = j_wide[COL_W-1:0];
                  rsp_value_in = '0;
                  rsp_ovf_in   = 1'b0;
                  rsp_last_in  = (j_ff == bound_ff);
               end
               if (j_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end
         end
         ST_PRIME: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (j_ff == '0) begin
               mid_in = prev_rd;
            end
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            right_in = prev_rd;
            acc_in   = src_term - older_term + half_term;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in   = acc_ff + prod_ext;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + (prod_ext <<< 1);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               wr_en        = 1'b1;
               prev_wdata   = fresh;
               older_wdata  = mid_ff;
               rsp_valid_in = 1'b1;
               rsp_col_in   = j_wide[COL_W-1:0];
               rsp_value_in = fresh;
               rsp_ovf_in   = fresh_ovf;
               rsp_last_in  = (j_ff == bound_ff);
               // Slide the window of old row values one column right
               left_in      = mid_ff;
               mid_in       = right_ff;
               if (j_ff == bound_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Register writes
   always_comb begin
      a2_in       = a2_ff;
      src_col_in  = src_col_ff;
      last_col_in = last_col_ff;
      if (csr_write) begin
         case (csr_paddr[CSR_ADDR_W-1:2])
            REG_ALPHA_SQUARED: a2_in       = csr_pwdata[A2_W-1:0];
            REG_SOURCE_COLUMN: src_col_in  = csr_pwdata[COL_W-1:0];
            REG_LAST_COLUMN:   last_col_in = csr_pwdata[COL_W-1:0];
            default: begin
               a2_in = a2_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_ADDR_W-1:2])
         REG_ALPHA_SQUARED: csr_prdata = CSR_DATA_W'(a2_ff);
         REG_SOURCE_COLUMN: csr_prdata = CSR_DATA_W'(src_col_ff);
         REG_LAST_COLUMN:   csr_prdata = CSR_DATA_W'(last_col_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
         a2_ff        <= ALPHA_SQUARED_RST;
         src_col_ff   <= SOURCE_COLUMN_RST;
         last_col_ff  <= LAST_COLUMN_RST;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         a2_ff        <= a2_in;
         src_col_ff   <= src_col_in;
         last_col_ff  <= last_col_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      bound_ff     <= bound_in;
      src_ff       <= src_in;
      left_ff      <= left_in;
      mid_ff       <= mid_in;
      right_ff     <= right_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_value_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;

endmodule

### bench/tb_wave_equation_fd_stepper.sv
// Self-checking bench for wave_equation_fd_stepper: directed steps, then random steps under
// changing register settings, every grid value checked against an in-bench stencil model.
// Depends on wefd_pkg and the stepper RTL.
module tb_wave_equation_fd_stepper;
   timeunit 1ns;
   timeprecision 1ps;

   import wefd_pkg::*;

   localparam int COLS       = MAX_COLUMNS_DEF;
   localparam int FRAC       = FRAC_BITS_DEF;
   localparam int ITEM_TOTAL = 370;
   localparam int DRAIN_CYCLES = 400;

   typedef enum logic {ROW_STEP, ROW_CONFIG} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      csr_reg_type     reg_sel;
      logic [31:0]     reg_value;
      logic            restart;
      logic [31:0]     sample;
      logic            typed_zero;
   } stim_row_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [VAL_W-1:0] value;
      logic             overflow;
      logic             last;
   } grid_value_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [VAL_W-1:0]      req_tdata;   // [31:0] source_sample
   logic [0:0]            req_tuser;   // [0] restart
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [5:0] column, [37:6] value, [39:38] zero
   logic [0:0]            rsp_tuser;   // [0] overflow
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   wave_equation_fd_stepper u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Stencil model state and its copy of the registers
   logic signed [VAL_W-1:0] grid_now [COLS];
   logic signed [VAL_W-1:0] grid_old [COLS];
   logic [1:0]              steps_done;
   logic [A2_W-1:0]         cfg_alpha;
   logic [COL_W-1:0]        cfg_source;
   logic [COL_W-1:0]        cfg_last;
   logic [VAL_W-1:0]        step_value [COLS];
   logic                    step_ovf [COLS];

   grid_value_type pending_values[$];
   stim_row_type   directed_rows[$];

   int items_sent;
   int values_seen;
   int overflow_seen;
   int csr_writes;
   int mismatch_count;
   int send_idle_pct;
   int recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d grid values still pending", pending_values.size());
      $display("tb_wave_equation_fd_stepper NOT OK");
      $finish;
   end

   function automatic stim_row_type step_row(logic restart, logic [31:0] sample,
                                             logic typed_zero);
      stim_row_type row;
      row = '{ROW_STEP, REG_ALPHA_SQUARED, 32'd0, restart, sample, typed_zero};
      return row;
   endfunction

   function automatic stim_row_type cfg_row(csr_reg_type sel, logic [31:0] value);
      stim_row_type row;
      row = '{ROW_CONFIG, sel, value, 1'b0, 32'd0, 1'b0};
      return row;
   endfunction

   // Advance the model grid one time step; fills step_value/step_ovf, returns the boundary.
   function automatic int unsigned advance_grid(logic restart, logic signed [VAL_W-1:0] sample);
      int unsigned bound;
      longint one, a2, acc, q, left, right, vmax, vmin;
      logic signed [VAL_W-1:0] fresh [COLS];
      logic fresh_ovf [COLS];
      one  = longint'(1) << FRAC;
      a2   = longint'(cfg_alpha);
      vmax = longint'(signed'(VALUE_MAX));
      vmin = longint'(signed'(VALUE_MIN));
      bound = (cfg_last > COLS - 1) ? COLS - 1 : cfg_last;
      if (restart)
         steps_done = 2'd0;
      for (int j = 0; j < COLS; j++) begin
         fresh[j] = '0;
         fresh_ovf[j] = 1'b0;
      end
      if (steps_done < PHASE_RUN) begin
         for (int j = 0; j < COLS; j++) begin
            grid_now[j] = '0;
            grid_old[j] = '0;
         end
      end else begin
         for (int j = 1; j < bound; j++) begin
            // boundary columns act as zero neighbours whatever the rows hold
            left  = (j - 1 == 0) ? 0 : longint'(grid_now[j-1]);
            right = (j + 1 >= bound) ? 0 : longint'(grid_now[j+1]);
            acc = -longint'(grid_old[j]) * one;
            acc += 2 * (one - a2) * longint'(grid_now[j]);
            acc += a2 * (left + right);
            if (j == cfg_source)
               acc += longint'(sample) * one;
            q = (acc + (one >>> 1)) >>> FRAC;
            if (q > vmax) begin
               q = vmax;
               fresh_ovf[j] = 1'b1;
            end else if (q < vmin) begin
               q = vmin;
               fresh_ovf[j] = 1'b1;
            end
            fresh[j] = q[VAL_W-1:0];
         end
         for (int j = 0; j <= bound; j++) begin
            grid_old[j] = grid_now[j];
            grid_now[j] = fresh[j];
         end
      end
      for (int j = 0; j <= bound; j++) begin
         step_value[j] = fresh[j];
         step_ovf[j]   = fresh_ovf[j];
      end
      if (steps_done < PHASE_RUN)
         steps_done++;
      return bound;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Leaves req_tvalid high on return so back-to-back items keep it asserted.
   task automatic send_step(logic restart, logic [31:0] sample, logic typed_zero);
      int unsigned bound;
      grid_value_type want;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      bound = advance_grid(restart, sample);
      for (int j = 0; j <= bound; j++) begin
         want.column   = j[COL_W-1:0];
         want.value    = typed_zero ? '0 : step_value[j];
         want.overflow = typed_zero ? 1'b0 : step_ovf[j];
         want.last     = (j == bound);
         pending_values.push_back(want);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // Write one register once the stepper has drained and sits between steps.
   task automatic write_csr(csr_reg_type sel, logic [31:0] value);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_values.size() != 0 || !req_tready);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (sel)
         REG_ALPHA_SQUARED: cfg_alpha  = value[A2_W-1:0];
         REG_SOURCE_COLUMN: cfg_source = value[COL_W-1:0];
         REG_LAST_COLUMN:   cfg_last   = value[COL_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_values
      grid_value_type got;
      grid_value_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.column   = rsp_tdata[COL_W-1:0];
         got.value    = rsp_tdata[COL_W +: VAL_W];
         got.overflow = rsp_tuser[0];
         got.last     = rsp_tlast;
         values_seen++;
         if (got.overflow)
            overflow_seen++;
         if (pending_values.size() == 0) begin
            report_mismatch($sformatf("unexpected value col %0d val %h", got.column,
                                      got.value));
         end else begin
            want = pending_values.pop_front();
            if (got.column !== want.column)
               report_mismatch($sformatf("column got %0d want %0d", got.column, want.column));
            if (got.value !== want.value)
               report_mismatch($sformatf("col %0d value got %h want %h", want.column,
                                         got.value, want.value));
            if (got.overflow !== want.overflow)
               report_mismatch($sformatf("col %0d overflow got %b want %b", want.column,
                                         got.overflow, want.overflow));
            if (got.last !== want.last)
               report_mismatch($sformatf("col %0d last got %b want %b", want.column,
                                         got.last, want.last));
         end
      end
   end

   initial begin
      logic [31:0] sample;
      logic [31:0] alpha_pick;
      int unsigned last_pick;
      int unsigned source_pick;
      int unsigned run_len;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      items_sent     = 0;
      values_seen    = 0;
      overflow_seen  = 0;
      csr_writes     = 0;
      mismatch_count = 0;
      send_idle_pct  = 35;
      recv_idle_pct  = 66;
      cfg_alpha  = ALPHA_SQUARED_RST;
      cfg_source = SOURCE_COLUMN_RST;
      cfg_last   = LAST_COLUMN_RST;
      steps_done = 2'd0;
      for (int j = 0; j < COLS; j++) begin
         grid_now[j] = '0;
         grid_old[j] = '0;
      end

      // first two steps after reset are all zero, source ignored
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b1));
      directed_rows.push_back(step_row(1'b0, 32'h8000_0000, 1'b1));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b0));
      directed_rows.push_back(step_row(1'b0, 32'h8000_0000, 1'b0));
      directed_rows.push_back(step_row(1'b0, 32'h0001_0000, 1'b0));
      directed_rows.push_back(cfg_row(REG_ALPHA_SQUARED, 32'd0));
      directed_rows.push_back(step_row(1'b0, 32'hffff_0000, 1'b0));
      directed_rows.push_back(step_row(1'b0, 32'h0000_0000, 1'b0));
      directed_rows.push_back(cfg_row(REG_ALPHA_SQUARED, 32'd131072));
      directed_rows.push_back(step_row(1'b0, 32'h1234_5678, 1'b0));
      directed_rows.push_back(step_row(1'b0, 32'hedcb_a988, 1'b0));
      // all alpha bits set: the grid blows up and saturates
      directed_rows.push_back(cfg_row(REG_ALPHA_SQUARED, 32'd262143));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b0));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b0));
      directed_rows.push_back(step_row(1'b0, 32'h8000_0000, 1'b0));
      // narrow grids have no interior
      directed_rows.push_back(cfg_row(REG_LAST_COLUMN, 32'd1));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b1));
      directed_rows.push_back(cfg_row(REG_LAST_COLUMN, 32'd0));
      directed_rows.push_back(step_row(1'b0, 32'h8000_0000, 1'b1));
      // source on column zero, on the boundary and past it
      directed_rows.push_back(cfg_row(REG_LAST_COLUMN, 32'd6));
      directed_rows.push_back(cfg_row(REG_ALPHA_SQUARED, 32'd32768));
      directed_rows.push_back(cfg_row(REG_SOURCE_COLUMN, 32'd0));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b0));
      directed_rows.push_back(cfg_row(REG_SOURCE_COLUMN, 32'd6));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b0));
      directed_rows.push_back(cfg_row(REG_SOURCE_COLUMN, 32'd9));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b0));
      directed_rows.push_back(cfg_row(REG_SOURCE_COLUMN, 32'd3));
      directed_rows.push_back(step_row(1'b0, 32'h0040_0000, 1'b0));
      // widen the grid mid-run, then restart
      directed_rows.push_back(cfg_row(REG_LAST_COLUMN, 32'd10));
      directed_rows.push_back(step_row(1'b0, 32'h0000_0000, 1'b0));
      directed_rows.push_back(step_row(1'b1, 32'h7fff_ffff, 1'b1));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b1));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b0));
      directed_rows.push_back(cfg_row(REG_LAST_COLUMN, 32'd63));
      directed_rows.push_back(cfg_row(REG_SOURCE_COLUMN, 32'd62));
      directed_rows.push_back(step_row(1'b0, 32'h8000_0000, 1'b0));
      directed_rows.push_back(cfg_row(REG_SOURCE_COLUMN, 32'd1));
      directed_rows.push_back(step_row(1'b0, 32'h7fff_ffff, 1'b0));

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CONFIG)
            write_csr(directed_rows[i].reg_sel, directed_rows[i].reg_value);
         else
            send_step(directed_rows[i].restart, directed_rows[i].sample,
                      directed_rows[i].typed_zero);
      end

      while (items_sent < ITEM_TOTAL) begin
         if (items_sent < 130) begin
            send_idle_pct = 35;
            recv_idle_pct = 66;
         end else if (items_sent < 250) begin
            send_idle_pct = 66;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         case ($urandom_range(7))
            0:       alpha_pick = 32'd0;
            1:       alpha_pick = 32'd131072;
            2:       alpha_pick = $urandom_range(262143, 131073);
            3:       alpha_pick = 32'd65536;
            default: alpha_pick = $urandom_range(131072, 0);
         endcase
         case ($urandom_range(9))
            0:       last_pick = 63;
            1:       last_pick = $urandom_range(1, 0);
            2:       last_pick = $urandom_range(62, 16);
            default: last_pick = $urandom_range(15, 2);
         endcase
         if ($urandom_range(3) == 0 || last_pick < 2)
            source_pick = $urandom_range(63, 0);
         else
            source_pick = $urandom_range(last_pick - 1, 1);

         write_csr(REG_ALPHA_SQUARED, alpha_pick);
         write_csr(REG_LAST_COLUMN, last_pick);
         write_csr(REG_SOURCE_COLUMN, source_pick);

         // keep wide grids to short runs
         run_len = (last_pick >= 32) ? $urandom_range(5, 2) : $urandom_range(18, 6);
         repeat (run_len) begin
            case ($urandom_range(5))
               0:       sample = $urandom;
               1:       sample = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
               2, 3:    sample = $urandom_range(32'h0020_0000) - 32'h0010_0000;
               default: sample = $urandom_range(32'h0800_0000) - 32'h0400_0000;
            endcase
            send_step($urandom_range(19) == 0, sample, 1'b0);
         end
      end

      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_values.size() != 0);
      // catch any stray value after the last step
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("ran %0d steps, %0d grid values (%0d saturated), %0d register writes",
               items_sent, values_seen, overflow_seen, csr_writes);
      $display("mismatches: %0d, values left pending: %0d", mismatch_count,
               pending_values.size());
      if (mismatch_count == 0 && pending_values.size() == 0) begin
         $display("tb_wave_equation_fd_stepper OK");
      end else begin
         $display("tb_wave_equation_fd_stepper NOT OK");
      end
      $finish;
   end

endmodule
